/* rtl/b64sc_pkg.sv */
// shared types, alphabet tables and sizes for the base64 stream codec
package b64sc_pkg;

  localparam int unsigned ValueW = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // one result beat
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic              error;
  } result_t;

  // symbol lookup result for decode
  typedef struct packed {
    logic               valid;
    logic [SextetW-1:0] index;
  } sym_t;

  // sextet to ascii symbol
  function automatic logic [ValueW-1:0] enc_sym(input logic [SextetW-1:0] six);
    logic [ValueW-1:0] code;
    code = {2'b00, six};
    if (six < 6'd26) begin
      code = 8'd65 + code;
    end else if (six < 6'd52) begin
      code = 8'd71 + code;
    end else if (six < 6'd62) begin
      code = code - 8'd4;
    end else if (six == 6'd62) begin
      code = 8'd43;
    end else begin
      code = 8'd95;
    end
    return code;
  endfunction

  // ascii symbol to sextet, valid low when outside the alphabet
  function automatic sym_t dec_sym(input logic [ValueW-1:0] v);
    sym_t s;
    logic [ValueW-1:0] t;
    s = '0;
    t = '0;
    if (v >= 8'd65 && v <= 8'd90) begin
      t = v - 8'd65;
      s.valid = 1'b1;
    end else if (v >= 8'd97 && v <= 8'd122) begin
      t = v - 8'd71;
      s.valid = 1'b1;
    end else if (v >= 8'd48 && v <= 8'd57) begin
      t = v + 8'd4;
      s.valid = 1'b1;
    end else if (v == 8'd43) begin
      t = 8'd62;
      s.valid = 1'b1;
    end else if (v == 8'd95) begin
      t = 8'd63;
      s.valid = 1'b1;
    end
    s.index = t[SextetW-1:0];
    return s;
  endfunction

endpackage

/* rtl/base64_stream_codec_top.sv */
// streaming unpadded base64 codec (alphabet A-Z a-z 0-9 + _) with a small result queue
//
// The block encodes bytes into base64 symbols (direction 0) or decodes symbols into
// bytes (direction 1), one input beat per cycle. Each accepted beat is turned into zero,
// one or two result beats in the same cycle by short logic and written into a four-entry
// result queue; the output side drains one beat per cycle while out_stall is low. An
// input beat is taken whenever at least two queue slots are free, so items that give one
// result stream at one per cycle while unstalled; an encode beat that gives two results
// (third byte of a group, or a last byte that flushes the held partial symbol) has its
// second result absorbed by the queue. in_last closes a stream: the phase counter and
// held bits clear, and on decode a trailing partial byte is dropped. A decode symbol
// outside the alphabet gives one beat with out_value 0, out_error 1 and out_last 1, and
// also ends the stream. A write of the direction register clears the stream state; it is
// always accepted (cfg_ready stays high) and is meant to be done while the block is idle.
module base64_stream_codec_top
  import b64sc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_direction,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ValueW-1:0] in_value,
  input  logic              in_last,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ValueW-1:0] out_value,
  output logic              out_last,
  output logic              out_error
);

  // stream state
  logic              direction;
  logic [1:0]        phase;
  logic [ValueW-1:0] pending;
  logic [1:0]        phase_next;
  logic [ValueW-1:0] pending_next;

  // results of the current beat
  result_t     res0;
  result_t     res1;
  logic [1:0]  res_cnt;

  // result queue
  result_t               queue [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;

  sym_t sym;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // take a beat only with room for two results
  assign in_stall  = (count > QueueCntW'(QueueDepth - 2));
  assign in_fire   = in_valid & ~in_stall;

  assign out_valid = (count != '0);
  assign out_fire  = out_valid & ~out_stall;
  assign out_value = queue[rd_ptr].value;
  assign out_last  = queue[rd_ptr].last;
  assign out_error = queue[rd_ptr].error;

  assign sym = dec_sym(in_value);

  // per-beat codec step
  always_comb begin
    res0         = '0;
    res1         = '0;
    res_cnt      = 2'd0;
    phase_next   = phase;
    pending_next = pending;
    if (direction == DirEncode) begin
      unique case (phase)
        2'd0: begin
          res0.value   = enc_sym(in_value[7:2]);
          res_cnt      = 2'd1;
          pending_next = {2'b00, in_value[1:0], 4'b0000};
          phase_next   = 2'd1;
        end
        2'd1: begin
          res0.value   = enc_sym(pending[5:0] | {2'b00, in_value[7:4]});
          res_cnt      = 2'd1;
          pending_next = {2'b00, in_value[3:0], 2'b00};
          phase_next   = 2'd2;
        end
        default: begin
          res0.value   = enc_sym(pending[5:0] | {4'b0000, in_value[7:6]});
          res1.value   = enc_sym(in_value[5:0]);
          res1.last    = in_last;
          res_cnt      = 2'd2;
          pending_next = '0;
          phase_next   = 2'd0;
        end
      endcase
      if (in_last) begin
        // flush the held partial symbol
        if (phase_next != 2'd0) begin
          res1.value = enc_sym(pending_next[5:0]);
          res1.last  = 1'b1;
          res_cnt    = 2'd2;
        end
        phase_next   = 2'd0;
        pending_next = '0;
      end
    end else begin
      if (!sym.valid) begin
        res0.value   = '0;
        res0.last    = 1'b1;
        res0.error   = 1'b1;
        res_cnt      = 2'd1;
        phase_next   = 2'd0;
        pending_next = '0;
      end else begin
        unique case (phase)
          2'd0: begin
            pending_next = {sym.index, 2'b00};
            phase_next   = 2'd1;
          end
          2'd1: begin
            res0.value   = pending | {6'b000000, sym.index[5:4]};
            res0.last    = in_last;
            res_cnt      = 2'd1;
            pending_next = {sym.index[3:0], 4'b0000};
            phase_next   = 2'd2;
          end
          2'd2: begin
            res0.value   = pending | {4'b0000, sym.index[5:2]};
            res0.last    = in_last;
            res_cnt      = 2'd1;
            pending_next = {sym.index[1:0], 6'b000000};
            phase_next   = 2'd3;
          end
          default: begin
            res0.value   = pending | {2'b00, sym.index};
            res0.last    = in_last;
            res_cnt      = 2'd1;
            pending_next = '0;
            phase_next   = 2'd0;
          end
        endcase
        if (in_last) begin
          phase_next   = 2'd0;
          pending_next = '0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DirEncode;
      phase     <= 2'd0;
      pending   <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (cfg_fire) begin
        direction <= cfg_direction;
        phase     <= 2'd0;
        pending   <= '0;
      end else if (in_fire) begin
        phase   <= phase_next;
        pending <= pending_next;
      end
      if (in_fire) begin
        wr_ptr <= wr_ptr + QueuePtrW'(res_cnt);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      count <= count + (in_fire ? QueueCntW'(res_cnt) : QueueCntW'(0))
                     - (out_fire ? QueueCntW'(1) : QueueCntW'(0));
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (res_cnt != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (res_cnt == 2'd2) begin
        queue[wr_ptr + QueuePtrW'(1)] <= res1;
      end
    end
  end

endmodule

/* verif/base64_stream_codec_checker.sv */
// checker for the base64 stream codec: predicts result beats and compares them
module base64_stream_codec_checker
  import b64sc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_direction,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [ValueW-1:0] in_value,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ValueW-1:0] out_value,
  input  logic              out_last,
  input  logic              out_error,
  output int                mismatches,
  output int                beats_checked,
  output int                error_beats,
  output int                beats_waiting
);

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+_";

  logic              mode;
  logic [1:0]        phase;
  logic [ValueW-1:0] held;
  result_t           owed_beats[$];

  function automatic logic [ValueW-1:0] sextet_char(input logic [SextetW-1:0] six);
    return Alphabet[8*(63-six) +: 8];
  endfunction

  // linear search of the alphabet, low when the code is not a symbol
  function automatic logic char_sextet(input logic [ValueW-1:0] ch,
                                       output logic [SextetW-1:0] six);
    logic hit;
    hit = 1'b0;
    six = '0;
    for (int i = 0; i < 64; i++) begin
      if (Alphabet[8*(63-i) +: 8] == ch) begin
        hit = 1'b1;
        six = i[SextetW-1:0];
      end
    end
    return hit;
  endfunction

  task automatic owe(input logic [ValueW-1:0] v, input logic l, input logic e);
    result_t r;
    r.value = v;
    r.last = l;
    r.error = e;
    owed_beats.push_back(r);
  endtask

  task automatic translate_beat(input logic [ValueW-1:0] v, input logic l);
    logic [SextetW-1:0] six;
    logic               ok;
    if (mode == DirEncode) begin
      case (phase)
        2'd0: begin
          owe(sextet_char(v[7:2]), 1'b0, 1'b0);
          held = {2'b00, v[1:0], 4'b0000};
          phase = 2'd1;
        end
        2'd1: begin
          owe(sextet_char(held[5:0] | {2'b00, v[7:4]}), 1'b0, 1'b0);
          held = {2'b00, v[3:0], 2'b00};
          phase = 2'd2;
        end
        default: begin
          owe(sextet_char(held[5:0] | {4'b0000, v[7:6]}), 1'b0, 1'b0);
          owe(sextet_char(v[5:0]), l, 1'b0);
          held = '0;
          phase = 2'd0;
        end
      endcase
      // flush the partial symbol at the end of the stream
      if (l) begin
        if (phase != 2'd0) owe(sextet_char(held[5:0]), 1'b1, 1'b0);
        phase = 2'd0;
        held = '0;
      end
    end else begin
      ok = char_sextet(v, six);
      if (!ok) begin
        owe('0, 1'b1, 1'b1);
        phase = 2'd0;
        held = '0;
      end else begin
        case (phase)
          2'd0: begin
            held = {six, 2'b00};
            phase = 2'd1;
          end
          2'd1: begin
            owe(held | {6'b0, six[5:4]}, l, 1'b0);
            held = {six[3:0], 4'b0000};
            phase = 2'd2;
          end
          2'd2: begin
            owe(held | {4'b0, six[5:2]}, l, 1'b0);
            held = {six[1:0], 6'b0};
            phase = 2'd3;
          end
          default: begin
            owe(held | {2'b00, six}, l, 1'b0);
            held = '0;
            phase = 2'd0;
          end
        endcase
        // a trailing partial byte is dropped
        if (l) begin
          phase = 2'd0;
          held = '0;
        end
      end
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (owed_beats.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat, expected none, got value %h last %b error %b",
               $time, out_value, out_last, out_error);
    end else begin
      want = owed_beats.pop_front();
      beats_checked++;
      if (out_error) error_beats++;
      if (out_value !== want.value) begin
        mismatches++;
        $display("%0t: out_value expected %h got %h", $time, want.value, out_value);
      end
      if (out_last !== want.last) begin
        mismatches++;
        $display("%0t: out_last expected %b got %b", $time, want.last, out_last);
      end
      if (out_error !== want.error) begin
        mismatches++;
        $display("%0t: out_error expected %b got %b", $time, want.error, out_error);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = DirEncode;
      phase = 2'd0;
      held = '0;
      owed_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode = cfg_direction;
        phase = 2'd0;
        held = '0;
      end
      if (in_valid && !in_stall) translate_beat(in_value, in_last);
      if (out_valid && !out_stall) check_beat();
    end
    beats_waiting = owed_beats.size();
  end

endmodule

/* verif/tb.sv */
// testbench top for the base64 stream codec: stimulus, idling and verdict
module tb;
  import b64sc_pkg::*;

  // symbols used to build well-formed decode streams
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+_";
  localparam int BlockBeats = 175;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_direction = DirEncode;
  logic              in_valid = 1'b0;
  logic [ValueW-1:0] in_value = '0;
  logic              in_last = 1'b0;
  logic              out_stall = 1'b0;
  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [ValueW-1:0] out_value;
  logic              out_last;
  logic              out_error;

  // idle odds in percent for each side
  int send_idle = 0;
  int recv_idle = 0;

  int beats_sent = 0;
  int streams_sent = 0;
  int bad_symbols = 0;

  int mismatches;
  int beats_checked;
  int error_beats;
  int beats_waiting;

  always #2 clk = ~clk;

  base64_stream_codec_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error)
  );

  base64_stream_codec_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error),
    .mismatches   (mismatches),
    .beats_checked(beats_checked),
    .error_beats  (error_beats),
    .beats_waiting(beats_waiting)
  );

  // receiver stalls at random, a fresh draw every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // one input beat: optional idle gap, then hold until accepted;
  // valid stays high on return so back-to-back beats need no reassignment
  task automatic send_beat(input logic [ValueW-1:0] v, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= l;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // stop sending and wait for every owed result; the first edge lets the
  // checker book the beat accepted at the current edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
  endtask

  // direction write only on an idle block; the extra cycles cover a last
  // decode symbol that is still in flight but gives no result
  task automatic write_direction(input logic d);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ValueW-1:0] good_symbol();
    int k;
    k = $urandom_range(63);
    return Alphabet[8*(63-k) +: 8];
  endfunction

  // codes outside the alphabet, spread over every gap between its ranges
  function automatic logic [ValueW-1:0] bad_symbol();
    logic [ValueW-1:0] v;
    case ($urandom_range(5))
      0: v = ValueW'($urandom_range(42, 0));
      1: v = ValueW'($urandom_range(47, 44));
      2: v = ValueW'($urandom_range(64, 58));
      3: v = ValueW'($urandom_range(94, 91));
      4: v = 8'd96;
      default: v = ValueW'($urandom_range(255, 123));
    endcase
    return v;
  endfunction

  task automatic encode_stream(input int n, input logic close);
    for (int i = 0; i < n; i++) begin
      send_beat(ValueW'($urandom_range(255)), close && (i == n - 1));
    end
    streams_sent++;
  endtask

  // break_at < 0 keeps the stream clean
  task automatic decode_stream(input int n, input logic close, input int break_at);
    logic [ValueW-1:0] s;
    for (int i = 0; i < n; i++) begin
      if (i == break_at) begin
        s = bad_symbol();
        bad_symbols++;
      end else begin
        s = good_symbol();
      end
      send_beat(s, close && (i == n - 1));
    end
    streams_sent++;
  endtask

  // mostly well-formed streams of random length; some left open, some
  // broken by a bad symbol, and a little raw noise on decode
  task automatic random_block(input logic d);
    int   stop_at;
    int   n;
    logic close;
    logic rewritten;
    rewritten = 1'b0;
    write_direction(d);
    stop_at = beats_sent + BlockBeats;
    while (beats_sent < stop_at) begin
      n = $urandom_range(9, 1);
      close = ($urandom_range(99) < 85);
      if (d == DirEncode) begin
        encode_stream(n, close);
      end else if ($urandom_range(99) < 10) begin
        send_beat(ValueW'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        decode_stream(n, close, ($urandom_range(99) < 10) ? $urandom_range(n - 1) : -1);
      end
      // sender holds off until the output side has caught up
      if ($urandom_range(99) < 3) wait_drained();
      // same-direction write halfway through a decode block clears any open stream
      if (!rewritten && d == DirDecode && beats_sent > stop_at - BlockBeats / 2) begin
        write_direction(d);
        rewritten = 1'b1;
      end
    end
  endtask

  initial begin
    send_idle = 24;
    recv_idle = 52;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed encode: full group closed on its third byte, one-byte flush,
    // two-byte flush, group crossing with flush
    write_direction(DirEncode);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'hFE, 1'b1);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'hF0, 1'b1);

    // directed decode: lone last symbol gives nothing, full group then a
    // last symbol at the start of a group, short stream, bad symbols at
    // phase 1 and phase 0, among them code zero and the top code, last on third symbol
    write_direction(DirDecode);
    send_beat("A", 1'b1);
    send_beat("Z", 1'b0);
    send_beat("z", 1'b0);
    send_beat("0", 1'b0);
    send_beat("_", 1'b0);
    send_beat("+", 1'b1);
    send_beat("A", 1'b0);
    send_beat("B", 1'b1);
    send_beat("9", 1'b0);
    send_beat(8'h2F, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    send_beat("c", 1'b1);
    streams_sent += 11;
    bad_symbols += 3;

    // random part under three idle mixes, both directions in each
    random_block(DirEncode);
    random_block(DirDecode);
    send_idle = 52;
    recv_idle = 24;
    random_block(DirEncode);
    random_block(DirDecode);
    send_idle = 0;
    recv_idle = 0;
    random_block(DirEncode);
    random_block(DirDecode);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d input beats in %0d streams, both directions, %0d bad symbols",
             beats_sent, streams_sent, bad_symbols);
    $display("%0d result beats compared, %0d of them error beats",
             beats_checked, error_beats);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
